FILE: hw/rtl/mixdc_pkg.sv
`timescale 1ns / 1ps
package mixdc_pkg;

  localparam int PHASE_W     = 27;
  localparam int PERIOD_W    = 25;
  localparam int BLK_CFG_W   = 11;
  localparam int ATTEN_W     = 4;
  localparam int NUM_CH      = 4;
  localparam int MIX_W       = 16;
  localparam int RAW_W       = 18;
  localparam int SAMPLE_W    = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam int BEEP_BIT      = NUM_CH + NUM_CH * ATTEN_W;
  localparam int FULL_SCALE    = 32768;
  localparam int DEFAULT_BLOCK = 128;

  // round(sum / 5) = floor((2 * sum + 5) / 10), by reciprocal
  localparam int               DIV10_IN_W   = RAW_W + 1;
  localparam int               DIV10_MULT_W = 20;
  localparam int               DIV10_SHIFT  = 23;
  localparam logic [19:0]      DIV10_MULT   = 20'd838861;

  localparam logic [MIX_W-1:0] VOL_Q15 [16] = '{
    16'd32768, 16'd26028, 16'd20677, 16'd16423, 16'd13045, 16'd10361, 16'd8231, 16'd6537,
    16'd5194,  16'd4125,  16'd3277,  16'd2602,  16'd2068,  16'd1642,  16'd1304, 16'd0
  };

  typedef enum logic {
    REG_TICK_PERIOD  = 1'b0,
    REG_BLOCK_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                load_period;
    logic [PERIOD_W-1:0] period;
  } front_ctl_t;

  typedef struct packed {
    logic clr_window;
    logic clr_block;
  } back_ctl_t;

endpackage

FILE: hw/rtl/psg_audio_mix_decimate_dc_block_unit.sv
`timescale 1ns / 1ps
// Tone mixer, decimator and moving-average DC blocker.
// Slave stream: one transfer per tone tick. Master stream: one transfer per
// produced sample, tlast set on the last sample of each block.
// Config port: tick_period at 0x0, block_length at 0x4. Write only while idle.
// A tick_period write reloads the phase counter and empties the window;
// either write restarts the block count. A period of zero stops all output.
// Throughput: one tick per cycle outside a master stall. The ring read address
// is known one stage ahead, so the window RAM does one read and one write per cycle.
// Path from the edge that accepts a tick to the edge that presents its sample
// on the master side: divide into the queue, RAM read, window sum, mean
// multiply, subtract into the output register.
// Reset: window entries read as zero until first written (fill flag), so no
// clearing pass; the block accepts ticks in the first cycle after reset.
// Master stall: the back pipeline holds, the 4-entry queue fills, then
// s_tready drops once the front register also holds a sample. Ticks that make
// no sample are taken as long as the front register is free.
module psg_audio_mix_decimate_dc_block_unit
  import mixdc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 512,
  parameter int TICK_STEP    = 128,
  parameter int MAX_BLOCK    = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // channel_on[3:0], atten_ch0[7:4], atten_ch1[11:8], atten_ch2[15:12],
  // atten_ch3[19:16], beep_level[20], zero[23:21]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // sample[16:0], zero[23:17]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int BLK_W = $clog2(((MAX_BLOCK > DEFAULT_BLOCK) ? MAX_BLOCK : DEFAULT_BLOCK) + 1);

  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic [PERIOD_W-1:0]  tick_period;
  logic [BLK_W-1:0]     block_length;
  logic [BLK_CFG_W-1:0] blk_wval;
  logic                 blk_legal;
  front_ctl_t           front_ctl;
  back_ctl_t            back_ctl;

  logic                 q_push;
  logic [MIX_W-1:0]     q_wdata;
  logic                 q_full;
  logic                 q_pop;
  logic [MIX_W-1:0]     q_rdata;
  logic                 q_valid;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[2]);
  assign blk_wval  = pwdata[BLK_CFG_W-1:0];
  assign blk_legal = (blk_wval != '0) && (CFG_DATA_W'(blk_wval) <= CFG_DATA_W'(MAX_BLOCK));

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period  <= '0;
      block_length <= BLK_W'(DEFAULT_BLOCK);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TICK_PERIOD:  tick_period  <= pwdata[PERIOD_W-1:0];
        REG_BLOCK_LENGTH: block_length <= blk_legal ? BLK_W'(blk_wval) : BLK_W'(DEFAULT_BLOCK);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TICK_PERIOD:  prdata = CFG_DATA_W'(tick_period);
      REG_BLOCK_LENGTH: prdata = CFG_DATA_W'(block_length);
      default:          prdata = '0;
    endcase
  end

  assign front_ctl.load_period = cfg_wr && (cfg_idx == REG_TICK_PERIOD);
  assign front_ctl.period      = front_ctl.load_period ? pwdata[PERIOD_W-1:0] : tick_period;
  assign back_ctl.clr_window   = cfg_wr && (cfg_idx == REG_TICK_PERIOD);
  assign back_ctl.clr_block    = cfg_wr;

  mixdc_front #(
    .TICK_STEP (TICK_STEP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .ctl       (front_ctl),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full)
  );

  mixdc_fifo #(
    .WIDTH (MIX_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_valid)
  );

  mixdc_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ctl          (back_ctl),
    .block_length (block_length),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue read while empty");

  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full)
    else $error("input stalled with room in the queue");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed(m_tdata[SAMPLE_W-1:0]) >= -17'sd32768) &&
                  ($signed(m_tdata[SAMPLE_W-1:0]) <= 17'sd32768)))
    else $error("sample out of range");
`endif

endmodule

FILE: hw/rtl/mixdc_ram.sv
`timescale 1ns / 1ps
module mixdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mixdc_fifo.sv
`timescale 1ns / 1ps
module mixdc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/mixdc_front.sv
`timescale 1ns / 1ps
module mixdc_front
  import mixdc_pkg::*;
#(
  parameter int TICK_STEP = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  front_ctl_t            ctl,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic                  push,
  output logic [MIX_W-1:0]      push_data,
  input  logic                  full
);

  localparam logic signed [PHASE_W:0] STEP      = (PHASE_W + 1)'(TICK_STEP);
  localparam logic signed [PHASE_W:0] PHASE_MIN = {2'b11, {(PHASE_W - 1){1'b0}}};

  logic signed [PHASE_W-1:0]                phase;
  logic signed [PHASE_W-1:0]                phase_next;
  logic signed [PHASE_W:0]                  ph_dec;
  logic signed [PHASE_W:0]                  ph_sat;
  logic signed [PHASE_W:0]                  ph_after;
  logic                                     hit;
  logic                                     enabled;
  logic                                     accept;
  logic [RAW_W-1:0]                         raw_sum;
  logic                                     f_valid;
  logic [RAW_W-1:0]                         f_sum;
  logic [DIV10_IN_W-1:0]                    div_in;
  logic [DIV10_IN_W+DIV10_MULT_W-1:0]       div_prod;

  assign enabled  = (ctl.period != '0);
  assign accept   = s_tvalid && s_tready;
  assign s_tready = !f_valid || !full;
  assign push     = f_valid && !full;

  assign ph_dec   = {phase[PHASE_W-1], phase} - STEP;
  assign ph_sat   = (ph_dec < PHASE_MIN) ? PHASE_MIN : ph_dec;
  assign hit      = ph_sat[PHASE_W] || (ph_sat == '0);
  assign ph_after = ph_sat + $signed({{(PHASE_W + 1 - PERIOD_W){1'b0}}, ctl.period});

  always_comb begin
    phase_next = hit ? ph_after[PHASE_W-1:0] : ph_sat[PHASE_W-1:0];
  end

  always_comb begin
    raw_sum = s_tdata[BEEP_BIT] ? RAW_W'(FULL_SCALE) : '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (s_tdata[ch]) begin
        raw_sum = raw_sum + RAW_W'(VOL_Q15[s_tdata[NUM_CH + ATTEN_W * ch +: ATTEN_W]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      f_valid <= 1'b0;
    end else begin
      if (ctl.load_period) begin
        phase <= $signed({{(PHASE_W - PERIOD_W){1'b0}}, ctl.period});
      end else if (accept && enabled) begin
        phase <= phase_next;
      end
      if (accept) begin
        f_valid <= enabled && hit;
      end else if (push) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_sum <= raw_sum;
    end
  end

  assign div_in    = {f_sum, 1'b0} + DIV10_IN_W'(5);
  assign div_prod  = div_in * DIV10_MULT;
  assign push_data = div_prod[DIV10_SHIFT +: MIX_W];

endmodule

FILE: hw/rtl/mixdc_back.sv
`timescale 1ns / 1ps
module mixdc_back
  import mixdc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 512,
  parameter int MAX_BLOCK    = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  back_ctl_t              ctl,
  input  logic [$clog2(((MAX_BLOCK > DEFAULT_BLOCK) ? MAX_BLOCK : DEFAULT_BLOCK) + 1)-1:0]
                                 block_length,
  input  logic                   q_valid,
  input  logic [MIX_W-1:0]       q_data,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int DEP_W      = $clog2(WINDOW_DEPTH);
  localparam int SUM_W      = $clog2(WINDOW_DEPTH * FULL_SCALE + 1);
  localparam int MEAN_SHIFT = SUM_W + DEP_W;
  localparam int MUL_W      = SUM_W + 2;
  localparam int BLK_W      = $clog2(((MAX_BLOCK > DEFAULT_BLOCK) ? MAX_BLOCK : DEFAULT_BLOCK) + 1);
  localparam logic [63:0] MEAN_MULT_FULL =
    ((64'd1 << MEAN_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [MUL_W-1:0] MEAN_MULT = MEAN_MULT_FULL[MUL_W-1:0];
  localparam logic [DEP_W-1:0] LAST_POS  = DEP_W'(WINDOW_DEPTH - 1);

  logic                     advance;
  logic [DEP_W-1:0]         wpos;
  logic                     wrapped;
  logic [SUM_W-1:0]         wsum;
  logic [BLK_W-1:0]         blk_pos;
  logic [BLK_W:0]           blk_inc;
  logic                     blk_end;

  logic                     b_valid;
  logic [MIX_W-1:0]         b_s;
  logic [DEP_W-1:0]         b_pos;
  logic [MIX_W-1:0]         rdata;
  logic [MIX_W-1:0]         old;
  logic [SUM_W-1:0]         sum_new;
  logic                     commit;

  logic                     c_valid;
  logic [MIX_W-1:0]         c_s;
  logic [SUM_W-1:0]         c_sum;
  logic                     c_last;

  logic                     p_valid;
  logic [MIX_W-1:0]         p_s;
  logic [SUM_W+MUL_W-1:0]   p_prod;
  logic                     p_last;
  logic [MIX_W-1:0]         mean;

  logic [SAMPLE_W-1:0]      out_sample;

  assign advance = !m_tvalid || m_tready;
  assign q_pop   = advance && q_valid;
  assign commit  = advance && b_valid;

  mixdc_ram #(
    .WIDTH (MIX_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (commit),
    .waddr (b_pos),
    .wdata (b_s),
    .re    (q_pop),
    .raddr (wpos),
    .rdata (rdata)
  );

  assign old     = wrapped ? rdata : '0;
  assign sum_new = wsum - SUM_W'(old) + SUM_W'(b_s);
  assign blk_inc = {1'b0, blk_pos} + 1'b1;
  assign blk_end = (blk_inc >= {1'b0, block_length});
  assign mean    = p_prod[MEAN_SHIFT +: MIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos     <= '0;
      wrapped  <= 1'b0;
      wsum     <= '0;
      blk_pos  <= '0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        b_valid  <= q_valid;
        c_valid  <= b_valid;
        p_valid  <= c_valid;
        m_tvalid <= p_valid;
      end
      if (ctl.clr_window) begin
        wpos    <= '0;
        wrapped <= 1'b0;
        wsum    <= '0;
      end else begin
        if (q_pop) begin
          wpos <= (wpos == LAST_POS) ? '0 : wpos + 1'b1;
        end
        if (commit) begin
          wsum <= sum_new;
          if (b_pos == LAST_POS) begin
            wrapped <= 1'b1;
          end
        end
      end
      if (ctl.clr_block) begin
        blk_pos <= '0;
      end else if (commit) begin
        blk_pos <= blk_end ? '0 : blk_inc[BLK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_s   <= q_data;
      b_pos <= wpos;
    end
    if (advance) begin
      c_s        <= b_s;
      c_sum      <= sum_new;
      c_last     <= blk_end;
      p_s        <= c_s;
      p_prod     <= c_sum * MEAN_MULT;
      p_last     <= c_last;
      out_sample <= {1'b0, p_s} - {1'b0, mean};
      m_tlast    <= p_last;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - SAMPLE_W){1'b0}}, out_sample};

endmodule
